// File: rtl/rwf_pkg.sv
// ----------------------------------------------------------------------------
// rwf_pkg
// Shared constants, types and helpers for the rack word fit filter.
// ----------------------------------------------------------------------------
package rwf_pkg;

    localparam int LETTER_COUNT   = 26;
    localparam int COUNT_BITS     = 4;
    localparam int INDEX_BITS     = 16;
    localparam int REG_LETTERS    = 13;
    localparam int FIELD_BITS     = 52;
    localparam int MASK_BITS      = 32;
    localparam int LENGTH_BITS    = 5;
    localparam int TILE_BITS      = 5;
    localparam int WILD_BITS      = 4;
    localparam int SUM_BITS       = 9;
    localparam int POP_BITS       = 6;
    localparam int CFG_INDEX_BITS = 2;

    localparam int GROUP_SIZE     = 7;
    localparam int GROUPS         = (LETTER_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int POP_GROUP_SIZE = 8;
    localparam int POP_GROUPS     = MASK_BITS / POP_GROUP_SIZE;
    localparam int POP_GROUP_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_RACK_A_TO_M = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RACK_N_TO_Z = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RACK_TILES  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WILDCARDS   = 2'd3;

    typedef logic [LETTER_COUNT-1:0][COUNT_BITS-1:0] t_letters;

    typedef struct packed {
        t_letters               counts;
        logic [MASK_BITS-1:0]   mask;
        logic [TILE_BITS-1:0]   tiles;
        logic [WILD_BITS-1:0]   wildcards;
    } t_rack;

    function automatic t_letters unpack_counts(
        input logic [FIELD_BITS-1:0] lo,
        input logic [FIELD_BITS-1:0] hi
    );
        t_letters res;
        res = '0;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (i < REG_LETTERS) begin
                res[i] = lo[i*COUNT_BITS +: COUNT_BITS];
            end else begin
                res[i] = hi[(i-REG_LETTERS)*COUNT_BITS +: COUNT_BITS];
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/rwf_word_if.sv
// ----------------------------------------------------------------------------
// rwf_word_if
// Word channel: one dictionary word per transaction.
// ----------------------------------------------------------------------------
interface rwf_word_if;
    logic                                 valid;
    logic                                 ready;
    logic [rwf_pkg::FIELD_BITS-1:0]       word_counts_a_to_m;
    logic [rwf_pkg::FIELD_BITS-1:0]       word_counts_n_to_z;
    logic [rwf_pkg::MASK_BITS-1:0]        word_letter_mask;
    logic [rwf_pkg::LENGTH_BITS-1:0]      word_length;
    logic [rwf_pkg::INDEX_BITS-1:0]       word_index;

    modport source (
        output valid, word_counts_a_to_m, word_counts_n_to_z, word_letter_mask,
               word_length, word_index,
        input  ready
    );
    modport sink (
        input  valid, word_counts_a_to_m, word_counts_n_to_z, word_letter_mask,
               word_length, word_index,
        output ready
    );
endinterface

// File: rtl/rwf_result_if.sv
// ----------------------------------------------------------------------------
// rwf_result_if
// Result channel: index, fit flag and shortfall of one tested word.
// ----------------------------------------------------------------------------
interface rwf_result_if;
    logic                             valid;
    logic                             ready;
    logic [rwf_pkg::INDEX_BITS-1:0]   result_index;
    logic                             fits;
    logic [rwf_pkg::SUM_BITS-1:0]     shortfall;

    modport source (
        output valid, result_index, fits, shortfall,
        input  ready
    );
    modport sink (
        input  valid, result_index, fits, shortfall,
        output ready
    );
endinterface

// File: rtl/rwf_rack_regs.sv
// ----------------------------------------------------------------------------
// rwf_rack_regs
// Rack configuration registers and the derived rack letter-presence mask.
// ----------------------------------------------------------------------------
module rwf_rack_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rwf_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [rwf_pkg::FIELD_BITS-1:0]       i_cfg_data,
    output rwf_pkg::t_rack                       o_rack
);
    import rwf_pkg::*;

    logic [FIELD_BITS-1:0] r_rack_lo;
    logic [FIELD_BITS-1:0] r_rack_hi;
    logic [TILE_BITS-1:0]  r_tiles;
    logic [WILD_BITS-1:0]  r_wild;
    t_letters              counts;
    logic [MASK_BITS-1:0]  mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rack_lo <= '0;
            r_rack_hi <= '0;
            r_tiles   <= '0;
            r_wild    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RACK_A_TO_M: r_rack_lo <= i_cfg_data;
                REG_RACK_N_TO_Z: r_rack_hi <= i_cfg_data;
                REG_RACK_TILES:  r_tiles   <= i_cfg_data[TILE_BITS-1:0];
                REG_WILDCARDS:   r_wild    <= i_cfg_data[WILD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        counts = unpack_counts(r_rack_lo, r_rack_hi);
        mask   = '0;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            mask[MASK_BITS-1-i] = |counts[i];
        end
    end

    assign o_rack.counts    = counts;
    assign o_rack.mask      = mask;
    assign o_rack.tiles     = r_tiles;
    assign o_rack.wildcards = r_wild;

endmodule

// File: rtl/rack_word_fit_filter.sv
// ----------------------------------------------------------------------------
// rack_word_fit_filter
// Tests each dictionary word against the configured rack of letter tiles and
// wildcards, returning its index, a fit flag and the letter shortfall.
//
//   Channel   Direction  Moves
//   i_word    in         letter counts, letter mask, length, index
//   o_result  out        result index, fit flag, shortfall
//   i_cfg_*   in         rack register writes, no read-back
//
// A word passes through three registered stages to a valid result, and one word
// can be accepted every cycle unless a stall on o_result backs up to i_word. The
// stages are letter differences, group sums with partial mask population counts,
// and the final totals and compares. Reset clears the rack registers and all
// stage valid bits. A stage holds while the one after it is full and stalled, so
// a result waiting on o_result leaves the earlier stages free to fill.
// ----------------------------------------------------------------------------
module rack_word_fit_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rwf_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [rwf_pkg::FIELD_BITS-1:0]       i_cfg_data,
    rwf_word_if.sink                             i_word,
    rwf_result_if.source                         o_result
);
    import rwf_pkg::*;

    t_rack rack;

    logic                       r_v1;
    t_letters                   r_s1_diff;
    logic [MASK_BITS-1:0]       r_s1_missing;
    logic                       r_s1_len_ok;
    logic [INDEX_BITS-1:0]      r_s1_index;

    logic                                           r_v2;
    logic [GROUPS-1:0][SUM_BITS-1:0]                r_s2_sum;
    logic [POP_GROUPS-1:0][POP_GROUP_BITS-1:0]      r_s2_pop;
    logic                                           r_s2_len_ok;
    logic [INDEX_BITS-1:0]                          r_s2_index;

    logic                       r_v3;
    logic                       r_s3_fits;
    logic [SUM_BITS-1:0]        r_s3_short;
    logic [INDEX_BITS-1:0]      r_s3_index;

    logic take1;
    logic take2;
    logic take3;

    t_letters                                       word_counts;
    t_letters                                       n_s1_diff;
    logic [GROUPS-1:0][SUM_BITS-1:0]                n_s2_sum;
    logic [POP_GROUPS-1:0][POP_GROUP_BITS-1:0]      n_s2_pop;
    logic [SUM_BITS-1:0]                            n_s3_short;
    logic [POP_BITS-1:0]                            missing_total;
    logic                                           n_s3_fits;

    rwf_rack_regs u_rack_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rack      (rack)
    );

    assign take3 = !r_v3 || o_result.ready;
    assign take2 = !r_v2 || take3;
    assign take1 = !r_v1 || take2;

    assign i_word.ready = take1;

    always_comb begin
        word_counts = unpack_counts(i_word.word_counts_a_to_m, i_word.word_counts_n_to_z);
        for (int i = 0; i < LETTER_COUNT; i++) begin
            if (word_counts[i] > rack.counts[i]) begin
                n_s1_diff[i] = word_counts[i] - rack.counts[i];
            end else begin
                n_s1_diff[i] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_s2_sum[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < LETTER_COUNT) begin
                    n_s2_sum[g] = n_s2_sum[g]
                                + SUM_BITS'(r_s1_diff[g * GROUP_SIZE + k]);
                end
            end
        end
        for (int g = 0; g < POP_GROUPS; g++) begin
            n_s2_pop[g] = '0;
            for (int k = 0; k < POP_GROUP_SIZE; k++) begin
                n_s2_pop[g] = n_s2_pop[g]
                            + POP_GROUP_BITS'(r_s1_missing[g * POP_GROUP_SIZE + k]);
            end
        end
    end

    always_comb begin
        n_s3_short    = '0;
        missing_total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_s3_short = n_s3_short + r_s2_sum[g];
        end
        for (int g = 0; g < POP_GROUPS; g++) begin
            missing_total = missing_total + POP_BITS'(r_s2_pop[g]);
        end
        n_s3_fits = r_s2_len_ok
                 && (missing_total <= POP_BITS'(rack.wildcards))
                 && (n_s3_short <= SUM_BITS'(rack.wildcards));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= i_word.valid;
            end
            if (take2) begin
                r_v2 <= r_v1;
            end
            if (take3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_s1_diff    <= n_s1_diff;
            r_s1_missing <= i_word.word_letter_mask & ~rack.mask;
            r_s1_len_ok  <= (TILE_BITS'(i_word.word_length) <= rack.tiles);
            r_s1_index   <= i_word.word_index;
        end
        if (take2) begin
            r_s2_sum    <= n_s2_sum;
            r_s2_pop    <= n_s2_pop;
            r_s2_len_ok <= r_s1_len_ok;
            r_s2_index  <= r_s1_index;
        end
        if (take3) begin
            r_s3_fits  <= n_s3_fits;
            r_s3_short <= n_s3_short;
            r_s3_index <= r_s2_index;
        end
    end

    assign o_result.valid        = r_v3;
    assign o_result.result_index = r_s3_index;
    assign o_result.fits         = r_s3_fits;
    assign o_result.shortfall    = r_s3_short;

`ifndef SYNTH
    a_accept_fills_stage1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_word.valid && i_word.ready) |=> r_v1)
        else $error("Accepted word did not reach the first stage.");

    a_stage2_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !take2) |=> (r_v2 && $stable(r_s2_sum) && $stable(r_s2_index)))
        else $error("Second stage changed while stalled.");

    a_fit_within_wildcards : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.fits)
            |-> (o_result.shortfall <= SUM_BITS'(rack.wildcards)))
        else $error("Fitting word reports a shortfall above the wildcards.");
`endif

endmodule
